// ===== rtl/core/register_read_count_scoreboard_unit_assert.svh =====
// assertion macros for the read-count scoreboard
`ifndef REGISTER_READ_COUNT_SCOREBOARD_UNIT_ASSERT_SVH
`define REGISTER_READ_COUNT_SCOREBOARD_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RRCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrcs check failed");

// next-cycle implication, checked out of reset
`define RRCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrcs check failed");

`endif

// ===== rtl/core/rrcs_pkg.sv =====
// shared constants and types of the read-count scoreboard
`default_nettype none
package rrcs_pkg;
  // parameter defaults
  localparam int NUM_WARPS_DEF      = 32;
  localparam int SLOTS_PER_WARP_DEF = 256;
  localparam int COUNT_WIDTH_DEF    = 8;

  // field widths
  localparam int OPND_N     = 6;
  localparam int REG_W      = 8;
  localparam int WARP_W     = 5;
  localparam int OP_W       = 2;
  localparam int STAGE_W    = 2;
  localparam int MODE_W     = 2;
  localparam int BLOOM_W    = 9;
  localparam int CMAX_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  // modulo lanes: dividend width and remainder width
  localparam int KEY_W  = 9;
  localparam int REM_W  = 12;
  localparam int STEP_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRACKING_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_MOD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_LIMIT    = 2'd2;

  // operation codes of an input item
  typedef enum logic [OP_W-1:0] {
    OP_RESERVE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CHECK   = 2'd2
  } op_t;

  // work class decided by the front end
  typedef enum logic [1:0] {
    CLS_NOP     = 2'd0,
    CLS_RESERVE = 2'd1,
    CLS_RELEASE = 2'd2,
    CLS_CHECK   = 2'd3
  } cls_t;

  // control part of a queued work descriptor
  typedef struct packed {
    cls_t              cls;
    logic [OPND_N-1:0] act;
  } work_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/rrcs_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module rrcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ===== rtl/core/rrcs_fifo.sv =====
// two-entry queue between the front end and the back end
`default_nettype none
module rrcs_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  empty,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/rrcs_front.sv =====
// front end: accepts items, classifies them and folds registers into slots
`default_nettype none
module rrcs_front #(
  parameter int NUM_WARPS      = rrcs_pkg::NUM_WARPS_DEF,
  parameter int SLOTS_PER_WARP = rrcs_pkg::SLOTS_PER_WARP_DEF,
  localparam int ADDR_W        = $clog2(NUM_WARPS * SLOTS_PER_WARP)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_push,
  output logic                                   in_full,
  input  wire logic [rrcs_pkg::OP_W-1:0]         in_operation,
  input  wire logic [rrcs_pkg::WARP_W-1:0]       in_warp,
  input  wire logic [rrcs_pkg::REG_W-1:0]        in_src_reg0,
  input  wire logic [rrcs_pkg::REG_W-1:0]        in_src_reg1,
  input  wire logic [rrcs_pkg::REG_W-1:0]        in_src_reg2,
  input  wire logic [rrcs_pkg::REG_W-1:0]        in_src_reg3,
  input  wire logic [rrcs_pkg::REG_W-1:0]        in_addr_reg1,
  input  wire logic [rrcs_pkg::REG_W-1:0]        in_addr_reg2,
  input  wire logic [rrcs_pkg::STAGE_W-1:0]      in_release_stage,
  input  wire logic [rrcs_pkg::MODE_W-1:0]       tracking_mode,
  input  wire logic [rrcs_pkg::BLOOM_W-1:0]      slot_mod,
  input  wire logic                              clearing,
  output logic                                   q_push,
  input  wire logic                              q_full,
  output rrcs_pkg::work_ctl_t                    q_ctl,
  output logic [rrcs_pkg::OPND_N-1:0][ADDR_W-1:0] q_addr
);
  import rrcs_pkg::*;

  localparam int SLOT_W  = $clog2(SLOTS_PER_WARP);
  // reciprocal wrap into the slot range, exact for every KEY_W-bit key
  localparam int SLOT_SH = KEY_W + $clog2(SLOTS_PER_WARP);
  localparam int PROD_W  = 2 * KEY_W + 1;
  localparam int RECIP   = (2 ** SLOT_SH + SLOTS_PER_WARP - 1) / SLOTS_PER_WARP;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MOD1 = 4'b0010,
    F_MOD2 = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t                state_r, state_nxt;
  cls_t                   cls_r, cls_nxt;
  logic [WARP_W-1:0]      warp_r, warp_nxt;
  logic [OPND_N-1:0]      nz_r, nz_nxt;
  logic [KEY_W-1:0]       div_r [OPND_N];
  logic [KEY_W-1:0]       div_nxt [OPND_N];
  logic [REM_W-1:0]       rem_r [OPND_N];
  logic [REM_W-1:0]       rem_nxt [OPND_N];
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [REG_W-1:0]       regs [OPND_N];
  logic [REM_W-1:0]       divisor;
  logic [REM_W-1:0]       shl [OPND_N];
  logic [REM_W-1:0]       rem_step [OPND_N];
  logic [PROD_W-1:0]      prod [OPND_N];
  logic [KEY_W-1:0]       quot [OPND_N];
  logic [REM_W-1:0]       fold [OPND_N];
  logic [SLOT_W-1:0]      slot [OPND_N];
  logic [OPND_N-1:0]      first;
  logic                   accept;
  logic                   last_step;
  logic                   warp_ok;
  cls_t                   cls_in;

  assign regs[0] = in_src_reg0;
  assign regs[1] = in_src_reg1;
  assign regs[2] = in_src_reg2;
  assign regs[3] = in_src_reg3;
  assign regs[4] = in_addr_reg1;
  assign regs[5] = in_addr_reg2;

  assign in_full   = (state_r != F_IDLE) || clearing;
  assign accept    = in_push && !in_full;
  assign last_step = (step_r == STEP_W'(KEY_W - 1));
  assign warp_ok   = (int'(in_warp) < NUM_WARPS);

  // classify the incoming item
  always_comb begin
    cls_in = CLS_NOP;
    if (tracking_mode != '0 && warp_ok) begin
      case (in_operation)
        OP_RESERVE: cls_in = CLS_RESERVE;
        OP_RELEASE: cls_in = (in_release_stage == tracking_mode) ? CLS_RELEASE : CLS_NOP;
        OP_CHECK:   cls_in = CLS_CHECK;
        default:    cls_in = CLS_NOP;
      endcase
    end
  end

  // one restoring-modulo step per lane by the configured modulus
  assign divisor = REM_W'(slot_mod);
  always_comb begin
    for (int i = 0; i < OPND_N; i++) begin
      shl[i]      = {rem_r[i][REM_W-2:0], div_r[i][KEY_W-1]};
      rem_step[i] = (shl[i] >= divisor) ? (shl[i] - divisor) : shl[i];
    end
  end

  // wrap each key into the slot range by reciprocal multiplication
  always_comb begin
    for (int i = 0; i < OPND_N; i++) begin
      prod[i] = PROD_W'(div_r[i]) * PROD_W'(RECIP);
      quot[i] = KEY_W'(prod[i] >> SLOT_SH);
      fold[i] = REM_W'(div_r[i]) - REM_W'(quot[i]) * REM_W'(SLOTS_PER_WARP);
    end
  end

  // first occurrence of each slot among nonzero operands
  always_comb begin
    for (int i = 0; i < OPND_N; i++) begin
      slot[i] = rem_r[i][SLOT_W-1:0];
    end
    for (int i = 0; i < OPND_N; i++) begin
      first[i] = nz_r[i];
      for (int j = 0; j < i; j++) begin
        if (nz_r[j] && slot[j] == slot[i]) begin
          first[i] = 1'b0;
        end
      end
    end
  end

  // descriptor toward the back end
  always_comb begin
    q_ctl.cls = cls_r;
    case (cls_r)
      CLS_RESERVE, CLS_RELEASE: q_ctl.act = first;
      CLS_CHECK:                q_ctl.act = OPND_N'(1);
      default:                  q_ctl.act = '0;
    endcase
    for (int i = 0; i < OPND_N; i++) begin
      q_addr[i] = ADDR_W'(warp_r) * ADDR_W'(SLOTS_PER_WARP) + ADDR_W'(slot[i]);
    end
  end
  assign q_push = (state_r == F_PUSH);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cls_nxt   = cls_r;
    warp_nxt  = warp_r;
    nz_nxt    = nz_r;
    step_nxt  = step_r;
    for (int i = 0; i < OPND_N; i++) begin
      div_nxt[i] = div_r[i];
      rem_nxt[i] = rem_r[i];
    end
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          cls_nxt  = cls_in;
          warp_nxt = in_warp;
          step_nxt = '0;
          for (int i = 0; i < OPND_N; i++) begin
            div_nxt[i] = KEY_W'(regs[i]);
            rem_nxt[i] = '0;
            nz_nxt[i]  = (regs[i] != '0);
          end
          state_nxt = (slot_mod != '0) ? F_MOD1 : F_MOD2;
        end
      end
      F_MOD1: begin
        step_nxt = step_r + STEP_W'(1);
        for (int i = 0; i < OPND_N; i++) begin
          div_nxt[i] = {div_r[i][KEY_W-2:0], 1'b0};
          rem_nxt[i] = rem_step[i];
        end
        if (last_step) begin
          step_nxt = '0;
          for (int i = 0; i < OPND_N; i++) begin
            div_nxt[i] = rem_step[i][KEY_W-1:0];
            rem_nxt[i] = '0;
          end
          state_nxt = F_MOD2;
        end
      end
      // land the slot of every lane in the remainder registers
      F_MOD2: begin
        for (int i = 0; i < OPND_N; i++) begin
          rem_nxt[i] = fold[i];
        end
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cls_r  <= cls_nxt;
    warp_r <= warp_nxt;
    nz_r   <= nz_nxt;
    step_r <= step_nxt;
    for (int i = 0; i < OPND_N; i++) begin
      div_r[i] <= div_nxt[i];
      rem_r[i] <= rem_nxt[i];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/rrcs_back.sv =====
// back end: clears the table, runs counter updates and holds the result
`default_nettype none
`include "register_read_count_scoreboard_unit_assert.svh"
module rrcs_back #(
  parameter int NUM_WARPS      = rrcs_pkg::NUM_WARPS_DEF,
  parameter int SLOTS_PER_WARP = rrcs_pkg::SLOTS_PER_WARP_DEF,
  parameter int COUNT_WIDTH    = rrcs_pkg::COUNT_WIDTH_DEF,
  localparam int ADDR_W        = $clog2(NUM_WARPS * SLOTS_PER_WARP)
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               q_empty,
  output logic                                    q_pop,
  input  wire rrcs_pkg::work_ctl_t                q_ctl,
  input  wire logic [rrcs_pkg::OPND_N-1:0][ADDR_W-1:0] q_addr,
  input  wire logic [rrcs_pkg::CMAX_W-1:0]        read_limit,
  output logic                                    clearing,
  output logic                                    ram_we,
  output logic [ADDR_W-1:0]                       ram_waddr,
  output logic [COUNT_WIDTH:0]                    ram_wdata,
  output logic [ADDR_W-1:0]                       ram_raddr,
  input  wire logic [COUNT_WIDTH:0]               ram_rdata,
  output logic                                    out_empty,
  input  wire logic                               out_pop,
  output logic                                    out_read_collision,
  output logic                                    out_write_collision,
  output logic                                    out_release_error
);
  import rrcs_pkg::*;

  localparam int DEPTH = NUM_WARPS * SLOTS_PER_WARP;
  localparam int CMP_W = (COUNT_WIDTH > CMAX_W) ? COUNT_WIDTH : CMAX_W;

  typedef enum logic [4:0] {
    B_CLEAR = 5'b00001,
    B_IDLE  = 5'b00010,
    B_READ  = 5'b00100,
    B_WRITE = 5'b01000,
    B_DONE  = 5'b10000
  } bstate_t;

  bstate_t                 state_r, state_nxt;
  logic [ADDR_W-1:0]       clr_r, clr_nxt;
  cls_t                    cls_r, cls_nxt;
  logic [OPND_N-1:0]       act_r, act_nxt;
  logic [OPND_N-1:0][ADDR_W-1:0] addr_r, addr_nxt;
  logic [2:0]              lane_r, lane_nxt;
  logic                    rd_r, rd_nxt;
  logic                    wr_r, wr_nxt;
  logic                    err_r, err_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_rd_r, out_rd_nxt;
  logic                    out_wr_r, out_wr_nxt;
  logic                    out_err_r, out_err_nxt;
  logic                    out_free;
  logic                    last_lane;
  logic                    ent_valid;
  logic [COUNT_WIDTH-1:0]  ent_count;
  logic [CMP_W-1:0]        cnt_ext;
  logic [CMP_W-1:0]        max_ext;
  logic [COUNT_WIDTH-1:0]  upd_count;

  assign clearing  = (state_r == B_CLEAR);
  assign out_free  = !out_valid_r || out_pop;
  assign last_lane = (lane_r == 3'(OPND_N - 1));
  assign q_pop     = (state_r == B_IDLE) && !q_empty;

  // entry read back from the table
  assign ent_valid = ram_rdata[COUNT_WIDTH];
  assign ent_count = ram_rdata[COUNT_WIDTH-1:0];
  assign cnt_ext   = CMP_W'(ent_count);
  assign max_ext   = CMP_W'(read_limit);

  // saturating count update
  always_comb begin
    if (cls_r == CLS_RESERVE) begin
      if (!ent_valid) begin
        upd_count = COUNT_WIDTH'(1);
      end else if (ent_count != '1) begin
        upd_count = ent_count + COUNT_WIDTH'(1);
      end else begin
        upd_count = ent_count;
      end
    end else begin
      upd_count = (ent_count != '0) ? (ent_count - COUNT_WIDTH'(1)) : ent_count;
    end
  end

  // table ports
  assign ram_raddr = addr_r[lane_r];
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r[lane_r];
    ram_wdata = {1'b1, upd_count};
    if (state_r == B_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (state_r == B_WRITE) begin
      ram_we = (cls_r == CLS_RESERVE) || (cls_r == CLS_RELEASE && ent_valid);
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cls_nxt       = cls_r;
    act_nxt       = act_r;
    addr_nxt      = addr_r;
    lane_nxt      = lane_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_rd_nxt    = out_rd_r;
    out_wr_nxt    = out_wr_r;
    out_err_nxt   = out_err_r;
    unique case (state_r)
      B_CLEAR: begin
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          cls_nxt   = q_ctl.cls;
          act_nxt   = q_ctl.act;
          addr_nxt  = q_addr;
          lane_nxt  = '0;
          rd_nxt    = 1'b0;
          wr_nxt    = 1'b0;
          err_nxt   = 1'b0;
          state_nxt = B_READ;
        end
      end
      B_READ: begin
        if (act_r[lane_r]) begin
          state_nxt = B_WRITE;
        end else if (last_lane) begin
          state_nxt = B_DONE;
        end else begin
          lane_nxt = lane_r + 3'd1;
        end
      end
      B_WRITE: begin
        case (cls_r)
          CLS_RELEASE: begin
            if (!ent_valid) begin
              err_nxt = 1'b1;
            end
          end
          CLS_CHECK: begin
            rd_nxt = ent_valid && (max_ext != '0) && (cnt_ext >= max_ext);
            wr_nxt = ent_valid && (ent_count != '0);
          end
          default: ;
        endcase
        if (last_lane) begin
          state_nxt = B_DONE;
        end else begin
          lane_nxt  = lane_r + 3'd1;
          state_nxt = B_READ;
        end
      end
      B_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = rd_r;
          out_wr_nxt    = wr_r;
          out_err_nxt   = err_r;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    cls_r     <= cls_nxt;
    act_r     <= act_nxt;
    addr_r    <= addr_nxt;
    lane_r    <= lane_nxt;
    rd_r      <= rd_nxt;
    wr_r      <= wr_nxt;
    err_r     <= err_nxt;
    out_rd_r  <= out_rd_nxt;
    out_wr_r  <= out_wr_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_empty           = !out_valid_r;
  assign out_read_collision  = out_rd_r;
  assign out_write_collision = out_wr_r;
  assign out_release_error   = out_err_r;

  // no work is taken while the table is being cleared
  `RRCS_ASSERT_NOW(a_no_pop_in_clear, state_r == B_CLEAR, !q_pop)
  // table writes only come from the clear sweep or an update step
  `RRCS_ASSERT_NOW(a_write_source, ram_we, state_r == B_CLEAR || state_r == B_WRITE)
  // a finished item always lands in the result register
  `RRCS_ASSERT_NEXT(a_result_loaded, state_r == B_DONE && out_free, out_valid_r)
endmodule
`default_nettype wire

// ===== rtl/core/register_read_count_scoreboard_unit.sv =====
// top level of the register read-count scoreboard
//
//  channel  direction  handshake        payload
//  in       in         in_push/in_full  operation, warp, six registers, release stage
//  out      out        out_empty/out_pop read_collision, write_collision, release_error
//  cfg      in         cfg_we           cfg_index, cfg_wdata
//
// after reset the table is swept to zero, all NUM_WARPS*SLOTS_PER_WARP entries (8192 by
// default), with in_full high. the front end takes one item at a time: accept, nine
// bit-serial modulo steps on all six lanes (skipped when the slot modulus is 0), a wrap
// into the slot range and a hand-off to the queue. the back end takes the work, visits
// each operand lane, reads back each active counter and posts the result. a waiting
// result stalls the back end, and the front end too once the two-entry queue is full.
`default_nettype none
module register_read_count_scoreboard_unit #(
  parameter int NUM_WARPS      = rrcs_pkg::NUM_WARPS_DEF,
  parameter int SLOTS_PER_WARP = rrcs_pkg::SLOTS_PER_WARP_DEF,
  parameter int COUNT_WIDTH    = rrcs_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_push,
  output logic                                   in_full,
  input  wire logic [rrcs_pkg::OP_W-1:0]         in_operation,
  input  wire logic [rrcs_pkg::WARP_W-1:0]       in_warp,
  input  wire logic [rrcs_pkg::REG_W-1:0]        in_src_reg0,
  input  wire logic [rrcs_pkg::REG_W-1:0]        in_src_reg1,
  input  wire logic [rrcs_pkg::REG_W-1:0]        in_src_reg2,
  input  wire logic [rrcs_pkg::REG_W-1:0]        in_src_reg3,
  input  wire logic [rrcs_pkg::REG_W-1:0]        in_addr_reg1,
  input  wire logic [rrcs_pkg::REG_W-1:0]        in_addr_reg2,
  input  wire logic [rrcs_pkg::STAGE_W-1:0]      in_release_stage,
  output logic                                   out_empty,
  input  wire logic                              out_pop,
  output logic                                   out_read_collision,
  output logic                                   out_write_collision,
  output logic                                   out_release_error,
  input  wire logic                              cfg_we,
  input  wire logic [rrcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rrcs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import rrcs_pkg::*;

  localparam int ADDR_W = $clog2(NUM_WARPS * SLOTS_PER_WARP);
  localparam int DEPTH  = NUM_WARPS * SLOTS_PER_WARP;
  localparam int Q_W    = $bits(work_ctl_t) + OPND_N * ADDR_W;

  logic [MODE_W-1:0]             mode_r;
  logic [BLOOM_W-1:0]            bloom_r;
  logic [CMAX_W-1:0]             cmax_r;
  logic                          clearing;
  logic                          q_push, q_full, q_pop, q_empty;
  work_ctl_t                     f_ctl, b_ctl;
  logic [OPND_N-1:0][ADDR_W-1:0] f_addr, b_addr;
  logic [Q_W-1:0]                q_rdata;
  logic                          ram_we;
  logic [ADDR_W-1:0]             ram_waddr, ram_raddr;
  logic [COUNT_WIDTH:0]          ram_wdata, ram_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      bloom_r <= '0;
      cmax_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRACKING_MODE: mode_r  <= cfg_wdata[MODE_W-1:0];
        CFG_SLOT_MOD:      bloom_r <= cfg_wdata[BLOOM_W-1:0];
        CFG_READ_LIMIT:    cmax_r  <= cfg_wdata[CMAX_W-1:0];
        default: ;
      endcase
    end
  end

  // front end
  rrcs_front #(
    .NUM_WARPS      (NUM_WARPS),
    .SLOTS_PER_WARP (SLOTS_PER_WARP)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_operation     (in_operation),
    .in_warp          (in_warp),
    .in_src_reg0      (in_src_reg0),
    .in_src_reg1      (in_src_reg1),
    .in_src_reg2      (in_src_reg2),
    .in_src_reg3      (in_src_reg3),
    .in_addr_reg1     (in_addr_reg1),
    .in_addr_reg2     (in_addr_reg2),
    .in_release_stage (in_release_stage),
    .tracking_mode    (mode_r),
    .slot_mod         (bloom_r),
    .clearing         (clearing),
    .q_push           (q_push),
    .q_full           (q_full),
    .q_ctl            (f_ctl),
    .q_addr           (f_addr)
  );

  // work queue
  rrcs_fifo #(
    .WIDTH (Q_W)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .wdata ({f_ctl, f_addr}),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );
  assign {b_ctl, b_addr} = q_rdata;

  // back end
  rrcs_back #(
    .NUM_WARPS      (NUM_WARPS),
    .SLOTS_PER_WARP (SLOTS_PER_WARP),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .q_ctl               (b_ctl),
    .q_addr              (b_addr),
    .read_limit          (cmax_r),
    .clearing            (clearing),
    .ram_we              (ram_we),
    .ram_waddr           (ram_waddr),
    .ram_wdata           (ram_wdata),
    .ram_raddr           (ram_raddr),
    .ram_rdata           (ram_rdata),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_read_collision  (out_read_collision),
    .out_write_collision (out_write_collision),
    .out_release_error   (out_release_error)
  );

  // counter table: valid bit over count
  rrcs_ram #(
    .WIDTH (COUNT_WIDTH + 1),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// self-checking testbench for the register read-count scoreboard
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rrcs_pkg::*;

  localparam int WARPS = 32;
  localparam int SLOTS = 256;
  localparam int CNT_TOP = 255;
  localparam int WATCHDOG_LIMIT = 60000;

  // one input item
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [WARP_W-1:0]  warp;
    logic [REG_W-1:0]   src0;
    logic [REG_W-1:0]   src1;
    logic [REG_W-1:0]   src2;
    logic [REG_W-1:0]   src3;
    logic [REG_W-1:0]   addr1;
    logic [REG_W-1:0]   addr2;
    logic [STAGE_W-1:0] stage;
  } instr_t;

  // one result item
  typedef struct packed {
    logic rd_coll;
    logic wr_coll;
    logic rel_err;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [OP_W-1:0] in_operation = '0;
  logic [WARP_W-1:0] in_warp = '0;
  logic [REG_W-1:0] in_src_reg0 = '0, in_src_reg1 = '0, in_src_reg2 = '0;
  logic [REG_W-1:0] in_src_reg3 = '0, in_addr_reg1 = '0, in_addr_reg2 = '0;
  logic [STAGE_W-1:0] in_release_stage = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_read_collision, out_write_collision, out_release_error;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  register_read_count_scoreboard_unit i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the table and configuration
  logic [MODE_W-1:0] sh_mode;
  logic [BLOOM_W-1:0] sh_bloom;
  logic [CMAX_W-1:0] sh_cmax;
  logic [7:0] sh_count [WARPS*SLOTS];
  logic sh_valid [WARPS*SLOTS];

  instr_t pending_instrs[$];
  verdict_t expected_verdicts[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int recv_hold = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  function automatic int slot_for(logic [REG_W-1:0] r);
    int key;
    key = (sh_bloom != 0) ? (int'(r) % int'(sh_bloom)) : int'(r);
    return key % SLOTS;
  endfunction

  // apply one item to the shadow table and return its verdict
  function automatic verdict_t score_instr(instr_t it);
    verdict_t v;
    logic [REG_W-1:0] regs [6];
    int seen [$];
    int base, s, idx;
    bit dup;
    v = '0;
    regs = '{it.src0, it.src1, it.src2, it.src3, it.addr1, it.addr2};
    if (sh_mode != 0 && int'(it.warp) < WARPS) begin
      base = int'(it.warp) * SLOTS;
      if (it.op == OP_RESERVE || (it.op == OP_RELEASE && it.stage == sh_mode)) begin
        foreach (regs[i]) begin
          if (regs[i] == 0) continue;
          s = slot_for(regs[i]);
          idx = base + s;
          if (it.op == OP_RELEASE && !sh_valid[idx]) begin
            v.rel_err = 1'b1;
            continue;
          end
          dup = 0;
          foreach (seen[j]) if (seen[j] == s) dup = 1;
          if (dup) continue;
          seen.push_back(s);
          if (it.op == OP_RESERVE) begin
            if (!sh_valid[idx]) begin
              sh_valid[idx] = 1'b1;
              sh_count[idx] = 8'd1;
            end else if (sh_count[idx] < CNT_TOP) begin
              sh_count[idx] = sh_count[idx] + 8'd1;
            end
          end else if (sh_count[idx] > 0) begin
            sh_count[idx] = sh_count[idx] - 8'd1;
          end
        end
      end else if (it.op == OP_CHECK) begin
        idx = base + slot_for(it.src0);
        if (sh_valid[idx]) begin
          v.rd_coll = (sh_cmax != 0) && (sh_count[idx] >= sh_cmax);
          v.wr_coll = (sh_count[idx] != 0);
        end
      end
    end
    return v;
  endfunction

  // driver: present queued items, predict on acceptance
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      expected_verdicts.push_back(score_instr({in_operation, in_warp, in_src_reg0,
        in_src_reg1, in_src_reg2, in_src_reg3, in_addr_reg1, in_addr_reg2,
        in_release_stage}));
      void'(pending_instrs.pop_front());
    end
    if (rst_n && (!in_push || !in_full)) begin
      if (pending_instrs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_push <= 1'b1;
        {in_operation, in_warp, in_src_reg0, in_src_reg1, in_src_reg2, in_src_reg3,
         in_addr_reg1, in_addr_reg2, in_release_stage} <= pending_instrs[0];
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor: compare accepted results, randomize pop
  always @(posedge clk) begin
    verdict_t got, exp_v;
    if (rst_n && out_pop && !out_empty) begin
      got = {out_read_collision, out_write_collision, out_release_error};
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %b", got);
      end else begin
        exp_v = expected_verdicts.pop_front();
        if (got !== exp_v) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: rd exp %b got %b, wr exp %b got %b, err exp %b got %b",
                     exp_v.rd_coll, got.rd_coll, exp_v.wr_coll, got.wr_coll,
                     exp_v.rel_err, got.rel_err);
        end
      end
    end
    if (recv_hold > 0) begin
      recv_hold--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any acceptance
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n || recv_hold > 0)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TRACKING_MODE: sh_mode = val[MODE_W-1:0];
      CFG_SLOT_MOD:      sh_bloom = val;
      default:           sh_cmax = val[CMAX_W-1:0];
    endcase
  endtask

  task automatic wait_drained();
    while (pending_instrs.size() != 0 || expected_verdicts.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [REG_W-1:0] pick_reg(int pool);
    // small pools make repeats and aliasing common
    if ($urandom_range(5) == 0) return '0;
    if (pool == 0) return REG_W'($urandom_range(255));
    return REG_W'(1 + $urandom_range(pool - 1));
  endfunction

  function automatic instr_t rand_instr(int pool, int warp_top);
    instr_t it;
    int r;
    it.warp = WARP_W'($urandom_range(warp_top));
    it.src0 = pick_reg(pool); it.src1 = pick_reg(pool); it.src2 = pick_reg(pool);
    it.src3 = pick_reg(pool); it.addr1 = pick_reg(pool); it.addr2 = pick_reg(pool);
    it.stage = (sh_mode != 0 && $urandom_range(3) != 0) ? sh_mode
                                                       : STAGE_W'($urandom_range(3));
    r = $urandom_range(99);
    it.op = (r < 40) ? OP_RESERVE : (r < 70) ? OP_RELEASE : (r < 97) ? OP_CHECK : 2'd3;
    return it;
  endfunction

  // stimulus
  initial begin
    int phase_cfg [7][3];
    instr_t it;
    foreach (sh_count[i]) begin
      sh_count[i] = '0;
      sh_valid[i] = 1'b0;
    end
    sh_mode = '0; sh_bloom = '0; sh_cmax = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);

    // directed: inert mode, then edge cases
    pending_instrs.push_back('{OP_RESERVE, 5'd3, 8'd9, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0});
    pending_instrs.push_back('{OP_CHECK, 5'd3, 8'd9, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0});
    wait_drained();
    write_cfg(CFG_TRACKING_MODE, 9'd1);
    write_cfg(CFG_SLOT_MOD, 9'd0);
    write_cfg(CFG_READ_LIMIT, 9'd2);
    pending_instrs.push_back('{OP_RESERVE, 5'd31, 8'd255, 8'd255, 8'd1, 8'd0, 8'd128,
                               8'd1, 2'd3});
    pending_instrs.push_back('{OP_CHECK, 5'd31, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0});
    pending_instrs.push_back('{OP_RESERVE, 5'd31, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0});
    pending_instrs.push_back('{OP_CHECK, 5'd31, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0});
    pending_instrs.push_back('{OP_RELEASE, 5'd31, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'd2});
    pending_instrs.push_back('{OP_RELEASE, 5'd31, 8'd255, 8'd77, 8'd128, 8'd0, 8'd0, 8'd1,
                               2'd1});
    pending_instrs.push_back('{OP_RELEASE, 5'd31, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 2'd1});
    pending_instrs.push_back('{OP_RELEASE, 5'd31, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'd1});
    pending_instrs.push_back('{OP_CHECK, 5'd31, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0});
    pending_instrs.push_back('{2'd3, 5'd0, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 2'd1});
    pending_instrs.push_back('{OP_CHECK, 5'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0});
    // raise six counters of warp 7 to 52 with repeated reserves
    for (int i = 0; i < 52; i++)
      pending_instrs.push_back('{OP_RESERVE, 5'd7, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14,
                                 8'd15, 2'd0});
    pending_instrs.push_back('{OP_CHECK, 5'd7, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0});
    // long receiver hold while items keep coming
    recv_hold = 400;
    wait_drained();
    write_cfg(CFG_READ_LIMIT, 9'd255);
    pending_instrs.push_back('{OP_CHECK, 5'd7, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0});
    wait_drained();

    // random phases: mode, slot modulus, read limit, sender idle, receiver stall
    phase_cfg = '{'{1, 0, 3}, '{2, 256, 1}, '{3, 7, 255}, '{1, 1, 0},
                  '{2, 16, 4}, '{3, 0, 2}, '{0, 5, 1}};
    for (int p = 0; p < 7; p++) begin
      write_cfg(CFG_TRACKING_MODE, CFG_DATA_W'(phase_cfg[p][0]));
      write_cfg(CFG_SLOT_MOD, CFG_DATA_W'(phase_cfg[p][1]));
      write_cfg(CFG_READ_LIMIT, CFG_DATA_W'(phase_cfg[p][2]));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      for (int n = 0; n < 190; n++) begin
        it = rand_instr((p % 2) ? 12 : 0, (p == 3) ? 31 : 3);
        pending_instrs.push_back(it);
      end
      wait_drained();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_verdicts.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
